FILE: hdl/frt_pkg.sv
// frt_pkg: shared constants and types for the range sum table
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package frt_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int POS_W      = 11;
  localparam int IDX_W      = POS_W + 1;
  localparam int DELTA_W    = 32;
  localparam int SUM_W      = 64;
  localparam int TDATA_W    = 72;

  localparam logic [POS_W-1:0] SIZE_MAX   = POS_W'(TABLE_SIZE);
  localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(1024);

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic sub;
    logic up;
  } alu_op_t;

endpackage

FILE: hdl/fenwick_range_sum_table_top.sv
// fenwick_range_sum_table_top: top level of the binary indexed range sum table
// depends on frt_pkg, frt_mem, frt_alu, frt_ctrl
`timescale 1ns / 1ps

// Binary indexed tree of 1024 signed 64-bit partial sums, one operation per
// input transfer. tuser selects a point add (0) or a range sum query (1).
// After reset the block clears its store with s_axis_tready low; cfg writes
// are taken during that time. All work goes through one store read port with
// a registered output and one shared 64-bit adder, so each touched entry
// takes a read state and then an add or accumulate state: an add walks up to
// 11 covering entries and gives no result; a query walks the high and low
// prefix chains, up to 20 entries. An add at position 0 or above the size
// register (capped at 1024) touches no entry. A query result is held in an
// output register, and the next transfer is accepted while it waits.

module fenwick_range_sum_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // position[10:0], delta[42:11], range_low[53:43], range_high[64:54], zero pad
  input  logic [frt_pkg::TDATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // range_sum[63:0]
  output logic [frt_pkg::SUM_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [frt_pkg::POS_W-1:0]     cfg_wdata
);
  import frt_pkg::*;

  logic [POS_W-1:0]   position;
  logic [DELTA_W-1:0] delta;
  logic [POS_W-1:0]   range_low;
  logic [POS_W-1:0]   range_high;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [SUM_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [SUM_W-1:0]   mem_rdata;
  alu_op_t            alu_op;
  logic [SUM_W-1:0]   alu_a;
  logic [SUM_W-1:0]   alu_b;
  logic [IDX_W-1:0]   alu_idx;
  logic [SUM_W-1:0]   alu_sum;
  logic [IDX_W-1:0]   alu_idx_step;

  assign position   = s_axis_tdata[10:0];
  assign delta      = s_axis_tdata[42:11];
  assign range_low  = s_axis_tdata[53:43];
  assign range_high = s_axis_tdata[64:54];

  frt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_mode       (s_axis_tuser),
    .in_position   (position),
    .in_delta      (delta),
    .in_range_low  (range_low),
    .in_range_high (range_high),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_sum       (m_axis_tdata),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .alu_op        (alu_op),
    .alu_a         (alu_a),
    .alu_b         (alu_b),
    .alu_idx       (alu_idx),
    .alu_sum       (alu_sum),
    .alu_idx_step  (alu_idx_step)
  );

  frt_alu u_alu (
    .op       (alu_op),
    .a        (alu_a),
    .b        (alu_b),
    .idx      (alu_idx),
    .sum      (alu_sum),
    .idx_step (alu_idx_step)
  );

  frt_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: hdl/frt_mem.sv
// frt_mem: partial sum store, one write and one registered read per cycle
// depends on frt_pkg
`timescale 1ns / 1ps

module frt_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [frt_pkg::ADDR_W-1:0] waddr,
  input  logic [frt_pkg::SUM_W-1:0]  wdata,
  input  logic [frt_pkg::ADDR_W-1:0] raddr,
  output logic [frt_pkg::SUM_W-1:0]  rdata
);
  import frt_pkg::*;

  logic [SUM_W-1:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/frt_alu.sv
// frt_alu: shared 64-bit add/subtract and lowest-set-bit index step
// depends on frt_pkg
`timescale 1ns / 1ps

module frt_alu (
  input  frt_pkg::alu_op_t          op,
  input  logic [frt_pkg::SUM_W-1:0] a,
  input  logic [frt_pkg::SUM_W-1:0] b,
  input  logic [frt_pkg::IDX_W-1:0] idx,
  output logic [frt_pkg::SUM_W-1:0] sum,
  output logic [frt_pkg::IDX_W-1:0] idx_step
);
  import frt_pkg::*;

  logic [IDX_W-1:0] low_bit;

  assign sum      = op.sub ? (a - b) : (a + b);
  assign low_bit  = idx & (~idx + IDX_W'(1));
  assign idx_step = op.up ? (idx + low_bit) : (idx - low_bit);

endmodule

FILE: hdl/frt_ctrl.sv
// frt_ctrl: sequencer for clear pass, point add walk and two-chain query walk
// depends on frt_pkg; drives frt_mem and frt_alu
`timescale 1ns / 1ps

module frt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [frt_pkg::POS_W-1:0]   in_position,
  input  logic [frt_pkg::DELTA_W-1:0] in_delta,
  input  logic [frt_pkg::POS_W-1:0]   in_range_low,
  input  logic [frt_pkg::POS_W-1:0]   in_range_high,
  input  logic                        cfg_we,
  input  logic [frt_pkg::POS_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [frt_pkg::SUM_W-1:0]   out_sum,
  output logic                        mem_we,
  output logic [frt_pkg::ADDR_W-1:0]  mem_waddr,
  output logic [frt_pkg::SUM_W-1:0]   mem_wdata,
  output logic [frt_pkg::ADDR_W-1:0]  mem_raddr,
  input  logic [frt_pkg::SUM_W-1:0]   mem_rdata,
  output frt_pkg::alu_op_t            alu_op,
  output logic [frt_pkg::SUM_W-1:0]   alu_a,
  output logic [frt_pkg::SUM_W-1:0]   alu_b,
  output logic [frt_pkg::IDX_W-1:0]   alu_idx,
  input  logic [frt_pkg::SUM_W-1:0]   alu_sum,
  input  logic [frt_pkg::IDX_W-1:0]   alu_idx_step
);
  import frt_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ADD_RD = 7'b0000100,
    ST_ADD_WR = 7'b0001000,
    ST_Q_RD   = 7'b0010000,
    ST_Q_ACC  = 7'b0100000,
    ST_Q_OUT  = 7'b1000000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_cnt;
  logic [POS_W-1:0]  size_in_use;
  logic [POS_W-1:0]  limit;
  logic [IDX_W-1:0]  idx;
  logic [POS_W-1:0]  low_bound;
  logic              phase_low;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  delta_ext;
  logic [POS_W-1:0]  hi_sat;
  logic [POS_W-1:0]  lo_m1;
  logic [POS_W-1:0]  lo_sat;
  logic              in_xfer;
  logic              out_free;

  assign limit   = (size_in_use > SIZE_MAX) ? SIZE_MAX : size_in_use;
  assign hi_sat  = (in_range_high > SIZE_MAX) ? SIZE_MAX : in_range_high;
  assign lo_m1   = (in_range_low == '0) ? '0 : (in_range_low - POS_W'(1));
  assign lo_sat  = (lo_m1 > SIZE_MAX) ? SIZE_MAX : lo_m1;
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // shared unit operand select
  always_comb begin
    alu_op.up  = (state == ST_ADD_WR);
    alu_op.sub = (state == ST_Q_ACC) && phase_low;
    alu_a      = (state == ST_ADD_WR) ? mem_rdata : acc;
    alu_b      = (state == ST_ADD_WR) ? delta_ext : mem_rdata;
    alu_idx    = idx;
  end

  always_comb begin
    mem_we    = (state == ST_CLEAR) || (state == ST_ADD_WR);
    mem_waddr = (state == ST_CLEAR) ? clr_cnt : idx[ADDR_W-1:0];
    mem_wdata = (state == ST_CLEAR) ? '0 : alu_sum;
    mem_raddr = idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      size_in_use <= SIZE_RESET;
      out_valid   <= 1'b0;
      phase_low   <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_in_use <= cfg_wdata;
      end
      if (out_valid && out_ready && state != ST_Q_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(TABLE_SIZE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_mode == MODE_ADD) begin
              idx       <= {1'b0, in_position};
              delta_ext <= {{(SUM_W-DELTA_W){in_delta[DELTA_W-1]}}, in_delta};
              if (in_position != '0 && in_position <= limit) begin
                state <= ST_ADD_RD;
              end
            end else begin
              idx       <= {1'b0, hi_sat};
              low_bound <= lo_sat;
              acc       <= '0;
              phase_low <= 1'b0;
              state     <= ST_Q_RD;
            end
          end
        end
        ST_ADD_RD: begin
          state <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          idx <= alu_idx_step;
          if (alu_idx_step > {1'b0, limit}) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_ADD_RD;
          end
        end
        ST_Q_RD: begin
          if (idx == '0) begin
            if (!phase_low) begin
              phase_low <= 1'b1;
              idx       <= {1'b0, low_bound};
            end else begin
              state <= ST_Q_OUT;
            end
          end else begin
            state <= ST_Q_ACC;
          end
        end
        ST_Q_ACC: begin
          acc   <= alu_sum;
          idx   <= alu_idx_step;
          state <= ST_Q_RD;
        end
        ST_Q_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_sum   <= acc;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/frt_checker.sv
// frt_checker: port-level assertions for the range sum table top
// depends on frt_pkg; bound to fenwick_range_sum_table_top
`timescale 1ns / 1ps

module frt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [frt_pkg::SUM_W-1:0]   m_axis_tdata
);
  import frt_pkg::*;

  // clear pass keeps the input closed right after reset
  a_clear_busy: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready during clear pass");

  // a query keeps the block busy for its walk
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
    else $error("input ready right after query transfer");

  // an add never produces a result
  a_add_silent: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_ADD) |=> !$rose(m_axis_tvalid))
    else $error("result after add transfer");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind fenwick_range_sum_table_top frt_checker u_frt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
